// File: src/glcd_pkg.sv
`default_nettype none

package glcd_pkg;

	localparam int unsigned YEAR_W  = 11;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned INDEX_W = 4;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned WORD_W  = 20;
	localparam int unsigned ROWS    = 100;
	localparam int unsigned ROW_W   = 7;

	localparam logic [YEAR_W-1:0]  EPOCH_YEAR       = 11'd1921;
	localparam logic [COUNT_W-1:0] EPOCH_OFFSET     = 16'd38;
	localparam logic [WORD_W-1:0]  SHORT_YEAR_LIMIT = 20'd4095;
	localparam int unsigned        LEAP_SHIFT       = 16;

	// Stem and branch of the first table year, (1921 - 4) mod 60 reduced.
	localparam logic [INDEX_W-1:0] STEM_FIRST   = 4'd7;
	localparam logic [INDEX_W-1:0] BRANCH_FIRST = 4'd9;
	localparam logic [INDEX_W-1:0] STEM_LAST    = 4'd9;
	localparam logic [INDEX_W-1:0] BRANCH_LAST  = 4'd11;

	localparam logic [8:0] DAYS_BEFORE_MONTH [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	localparam logic [WORD_W-1:0] LUNAR_YEARS [ROWS] = '{
		20'd2635, 20'd333387, 20'd1701, 20'd1748, 20'd267701,
		20'd694, 20'd2391, 20'd133423, 20'd1175, 20'd396438,
		20'd3402, 20'd3749, 20'd331177, 20'd1453, 20'd694,
		20'd201326, 20'd2350, 20'd465197, 20'd3221, 20'd3402,
		20'd400202, 20'd2901, 20'd1386, 20'd267611, 20'd605,
		20'd2349, 20'd137515, 20'd2709, 20'd464533, 20'd1738,
		20'd2901, 20'd330421, 20'd1242, 20'd2651, 20'd199255,
		20'd1323, 20'd529706, 20'd3733, 20'd1706, 20'd398762,
		20'd2741, 20'd1206, 20'd267438, 20'd2647, 20'd1318,
		20'd204070, 20'd3477, 20'd461653, 20'd1386, 20'd2413,
		20'd330077, 20'd1197, 20'd2637, 20'd268877, 20'd3365,
		20'd531109, 20'd2900, 20'd2922, 20'd398042, 20'd2395,
		20'd1179, 20'd267415, 20'd2635, 20'd661067, 20'd1701,
		20'd1748, 20'd398772, 20'd2742, 20'd2391, 20'd330031,
		20'd1175, 20'd1611, 20'd200010, 20'd3749, 20'd527717,
		20'd1452, 20'd2742, 20'd332397, 20'd2350, 20'd3222,
		20'd268949, 20'd3402, 20'd3493, 20'd133973, 20'd1386,
		20'd464219, 20'd605, 20'd2349, 20'd334123, 20'd2709,
		20'd2890, 20'd267946, 20'd2773, 20'd592565, 20'd1210,
		20'd2651, 20'd395863, 20'd1323, 20'd2707, 20'd265877
	};

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic               ok;
		logic [COUNT_W-1:0] count;
	} day_count_t;

	typedef struct packed {
		logic               hit;
		logic [COUNT_W-1:0] remainder;
	} month_step_t;

	typedef struct packed {
		logic               date_valid;
		logic [YEAR_W-1:0]  lunar_year;
		logic [MONTH_W-1:0] lunar_month;
		logic               leap_month;
		logic [DAY_W-1:0]   lunar_day;
		logic [INDEX_W-1:0] stem_index;
		logic [INDEX_W-1:0] branch_index;
	} result_t;

endpackage

`default_nettype wire

// File: src/glcd_if.sv
`default_nettype none

interface glcd_in_if import glcd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [YEAR_W-1:0]  solar_year;
	logic [MONTH_W-1:0] solar_month;
	logic [DAY_W-1:0]   solar_day;

	modport source (output valid, output solar_year, output solar_month,
		output solar_day, input ready);
	modport sink (input valid, input solar_year, input solar_month,
		input solar_day, output ready);
endinterface

interface glcd_out_if import glcd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               date_valid;
	logic [YEAR_W-1:0]  lunar_year;
	logic [MONTH_W-1:0] lunar_month;
	logic               leap_month;
	logic [DAY_W-1:0]   lunar_day;
	logic [INDEX_W-1:0] stem_index;
	logic [INDEX_W-1:0] branch_index;

	modport source (output valid, output date_valid, output lunar_year,
		output lunar_month, output leap_month, output lunar_day,
		output stem_index, output branch_index, input ready);
	modport sink (input valid, input date_valid, input lunar_year,
		input lunar_month, input leap_month, input lunar_day,
		input stem_index, input branch_index, output ready);
endinterface

`default_nettype wire

// File: src/glcd_day_count.sv
`default_nettype none

module glcd_day_count import glcd_pkg::*; (
	input  wire logic [YEAR_W-1:0]  year,
	input  wire logic [MONTH_W-1:0] month,
	input  wire logic [DAY_W-1:0]   day,
	output day_count_t              result
);

	logic [YEAR_W-1:0]  span_full;
	logic [6:0]         span;
	logic [MONTH_W-1:0] month_idx;
	logic               in_range;
	logic               leap_adj;
	logic [COUNT_W-1:0] sum;

	always_comb begin
		span_full = year - EPOCH_YEAR;
		span      = span_full[6:0];
		in_range  = (year >= EPOCH_YEAR) && (month inside {[4'd1:4'd12]});
		month_idx = in_range ? (month - 4'd1) : '0;
		leap_adj  = (year[1:0] == 2'b00) && (month > 4'd2);
		sum = COUNT_W'(span) * COUNT_W'(365) + COUNT_W'(span >> 2) + COUNT_W'(day)
			+ COUNT_W'(DAYS_BEFORE_MONTH[month_idx]) + COUNT_W'(leap_adj);
		result.ok    = in_range && (sum > EPOCH_OFFSET);
		result.count = sum - EPOCH_OFFSET;
	end

endmodule

`default_nettype wire

// File: src/glcd_month_unit.sv
`default_nettype none

module glcd_month_unit import glcd_pkg::*; (
	input  wire logic [COUNT_W-1:0] count,
	input  wire logic               long_month,
	output month_step_t             step
);

	logic [COUNT_W-1:0] len;

	// A month has 29 days, or 30 when its table bit is set.
	always_comb begin
		len            = COUNT_W'(29) + COUNT_W'(long_month);
		step.hit       = (count <= len);
		step.remainder = count - len;
	end

endmodule

`default_nettype wire

// File: src/gregorian_to_chinese_lunar_date.sv
`default_nettype none

// Gregorian to Chinese lunar date converter for the lunar years 1921 to 2020.
// A date transfer on the solar channel is taken while the converter is idle.
// In the cycle of the transfer the day count from 1921-02-08 (day 1) is formed
// and registered; the converter then walks the lunar year table one lunar
// month per cycle through a single compare-and-subtract unit, over the lunar
// months from the epoch up to and including the date's month (at most
// TABLE_YEARS * 13, about 1240 for the full table). Dates before the epoch or
// a month outside 1..12 give a result with date_valid low and all other
// fields zero and go to the output register without a table walk. A day count
// that runs past the table gives the same all-zero result, but only after the
// walk has gone through every month of the table.
// The result sits in an output register, so a new date may be transferred
// while the previous result still waits on the lunar channel. Stem and branch
// are tracked by wrapping counters that advance with the table row.
module gregorian_to_chinese_lunar_date import glcd_pkg::*; #(
	parameter int unsigned TABLE_YEARS = 100
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	glcd_in_if.sink     solar,
	glcd_out_if.source  lunar
);

	state_t             state_q, state_d;
	logic [COUNT_W-1:0] count_q;
	logic [ROW_W-1:0]   row_q;
	logic [MONTH_W-1:0] mon_q;
	logic [INDEX_W-1:0] stem_q, branch_q;
	result_t            pend_q, res_q;
	logic               out_valid_q;

	day_count_t         dc;
	month_step_t        step;

	logic [WORD_W-1:0]  word;
	logic               long_year;
	logic [MONTH_W-1:0] top;
	logic [MONTH_W-1:0] bit_idx;
	logic [12:0]        month_bits;
	logic [MONTH_W-1:0] leap_num;
	logic [MONTH_W:0]   leap_next;
	logic               last_month;
	logic               last_row;
	logic               accept;
	logic               load_out;
	result_t            hit_res;

	glcd_day_count u_day_count (
		.year   (solar.solar_year),
		.month  (solar.solar_month),
		.day    (solar.solar_day),
		.result (dc)
	);

	// The table word of the current row selects the length of the month
	// that the walk is on; bit 11 or 12 is the first month, bit 0 the last.
	always_comb begin
		word       = LUNAR_YEARS[row_q];
		long_year  = (word >= SHORT_YEAR_LIMIT);
		top        = long_year ? 4'd12 : 4'd11;
		bit_idx    = top - (mon_q - 4'd1);
		month_bits = word[12:0];
		leap_num   = word[LEAP_SHIFT +: MONTH_W];
		leap_next  = {1'b0, leap_num} + 5'd1;
		last_month = (bit_idx == '0);
		last_row   = (32'(row_q) == TABLE_YEARS - 1);
	end

	glcd_month_unit u_month_unit (
		.count      (count_q),
		.long_month (month_bits[bit_idx]),
		.step       (step)
	);

	// Result of a hit: the intercalary month repeats the number of the month
	// before it, and every later month of that year moves down by one.
	always_comb begin
		hit_res              = '0;
		hit_res.date_valid   = 1'b1;
		hit_res.lunar_year   = EPOCH_YEAR + YEAR_W'(row_q);
		hit_res.lunar_month  = mon_q;
		hit_res.lunar_day    = count_q[DAY_W-1:0];
		hit_res.stem_index   = stem_q;
		hit_res.branch_index = branch_q;
		if (long_year) begin
			if ({1'b0, mon_q} == leap_next) begin
				hit_res.lunar_month = leap_num;
				hit_res.leap_month  = 1'b1;
			end else if ({1'b0, mon_q} > leap_next) begin
				hit_res.lunar_month = mon_q - 4'd1;
			end
		end
	end

	assign accept   = solar.valid && solar.ready;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || lunar.ready);

	always_comb begin
		state_d     = state_q;
		solar.ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				solar.ready = 1'b1;
				if (solar.valid) begin
					state_d = dc.ok ? S_WALK : S_DONE;
				end
			end
			S_WALK: begin
				if (step.hit || (last_month && last_row)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (lunar.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk registers: payload only, so no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			count_q  <= dc.count;
			row_q    <= '0;
			mon_q    <= 4'd1;
			stem_q   <= STEM_FIRST;
			branch_q <= BRANCH_FIRST;
			pend_q   <= '0;
		end else if (state_q == S_WALK) begin
			if (step.hit) begin
				pend_q <= hit_res;
			end else begin
				count_q <= step.remainder;
				if (last_month) begin
					// Past the last table row the pending result stays zero.
					row_q    <= row_q + ROW_W'(1);
					mon_q    <= 4'd1;
					stem_q   <= (stem_q == STEM_LAST) ? '0 : stem_q + 4'd1;
					branch_q <= (branch_q == BRANCH_LAST) ? '0 : branch_q + 4'd1;
				end else begin
					mon_q <= mon_q + 4'd1;
				end
			end
		end
		if (load_out) begin
			res_q <= pend_q;
		end
	end

	assign lunar.valid        = out_valid_q;
	assign lunar.date_valid   = res_q.date_valid;
	assign lunar.lunar_year   = res_q.lunar_year;
	assign lunar.lunar_month  = res_q.lunar_month;
	assign lunar.leap_month   = res_q.leap_month;
	assign lunar.lunar_day    = res_q.lunar_day;
	assign lunar.stem_index   = res_q.stem_index;
	assign lunar.branch_index = res_q.branch_index;

`ifndef ASSERT_OFF
	// The remaining day count never reaches zero while the walk runs.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (count_q != '0))
		else $error("day count hit zero during the walk");

	// An invalid result carries all fields at zero.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(lunar.valid && !lunar.date_valid) |->
		(lunar.lunar_year == '0 && lunar.lunar_month == '0 &&
		 !lunar.leap_month && lunar.lunar_day == '0 &&
		 lunar.stem_index == '0 && lunar.branch_index == '0))
		else $error("invalid result with nonzero fields");

	// A valid result has a lunar day of 1 to 30.
	a_day_range: assert property (@(posedge clk) disable iff (!arst_n)
		(lunar.valid && lunar.date_valid) |->
		(lunar.lunar_day != '0 && lunar.lunar_day <= 5'd30))
		else $error("lunar day out of range");

	// A date transfer always starts work.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(solar.valid && solar.ready) |=> (state_q != S_IDLE))
		else $error("transfer taken without starting a conversion");
`endif

endmodule

`default_nettype wire

// File: tb/lunar_date_checker.sv
`default_nettype none

module lunar_date_checker import glcd_pkg::*; #(
	parameter int unsigned TABLE_YEARS = 100
) (
	input  wire logic clk,
	input  wire logic arst_n,
	glcd_in_if        solar,
	glcd_out_if       lunar,
	output int        failures,
	output int        pending,
	output int        results_seen,
	output int        valid_seen,
	output int        leap_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FIRST_YEAR  = 1921;
	localparam int unsigned EPOCH_SKEW  = 38;
	localparam int unsigned SHORT_WORD  = 4095;
	localparam int unsigned LEAP_POS    = 16;
	localparam int unsigned TABLE_ROWS  = 100;

	localparam int unsigned MONTH_START [12] = '{
		0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
	};

	localparam logic [19:0] YEAR_WORDS [TABLE_ROWS] = '{
		20'd2635, 20'd333387, 20'd1701, 20'd1748, 20'd267701,
		20'd694, 20'd2391, 20'd133423, 20'd1175, 20'd396438,
		20'd3402, 20'd3749, 20'd331177, 20'd1453, 20'd694,
		20'd201326, 20'd2350, 20'd465197, 20'd3221, 20'd3402,
		20'd400202, 20'd2901, 20'd1386, 20'd267611, 20'd605,
		20'd2349, 20'd137515, 20'd2709, 20'd464533, 20'd1738,
		20'd2901, 20'd330421, 20'd1242, 20'd2651, 20'd199255,
		20'd1323, 20'd529706, 20'd3733, 20'd1706, 20'd398762,
		20'd2741, 20'd1206, 20'd267438, 20'd2647, 20'd1318,
		20'd204070, 20'd3477, 20'd461653, 20'd1386, 20'd2413,
		20'd330077, 20'd1197, 20'd2637, 20'd268877, 20'd3365,
		20'd531109, 20'd2900, 20'd2922, 20'd398042, 20'd2395,
		20'd1179, 20'd267415, 20'd2635, 20'd661067, 20'd1701,
		20'd1748, 20'd398772, 20'd2742, 20'd2391, 20'd330031,
		20'd1175, 20'd1611, 20'd200010, 20'd3749, 20'd527717,
		20'd1452, 20'd2742, 20'd332397, 20'd2350, 20'd3222,
		20'd268949, 20'd3402, 20'd3493, 20'd133973, 20'd1386,
		20'd464219, 20'd605, 20'd2349, 20'd334123, 20'd2709,
		20'd2890, 20'd267946, 20'd2773, 20'd592565, 20'd1210,
		20'd2651, 20'd395863, 20'd1323, 20'd2707, 20'd265877
	};

	typedef struct {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		result_t            want;
	} solar_entry_t;

	solar_entry_t pending_dates [$];
	int           fail_count;

	assign failures = fail_count;

	// Converts one Gregorian date; anything that cannot be placed in the table
	// yields an all-zero result with date_valid low.
	function automatic result_t lunar_of_solar(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
		logic [DAY_W-1:0] d);
		result_t     r;
		int unsigned span, days, row, top, len, lm, mon, base;
		int          bit_i;
		logic [19:0] w;
		bit          hit;
		r = '0;
		if (y < FIRST_YEAR || m < 1 || m > 12)
			return r;
		span = y - FIRST_YEAR;
		days = span * 365 + span / 4 + d + MONTH_START[m - 1];
		if (y % 4 == 0 && m > 2)
			days++;
		if (days <= EPOCH_SKEW)
			return r;
		days -= EPOCH_SKEW;
		hit   = 1'b0;
		row   = 0;
		w     = '0;
		top   = 0;
		bit_i = 0;
		while (!hit && row < TABLE_YEARS && row < TABLE_ROWS) begin
			w     = YEAR_WORDS[row];
			top   = (w < SHORT_WORD) ? 11 : 12;
			bit_i = top;
			while (!hit && bit_i >= 0) begin
				len = 29 + w[bit_i];
				if (days <= len) begin
					hit = 1'b1;
				end else begin
					days -= len;
					bit_i--;
				end
			end
			if (!hit)
				row++;
		end
		if (!hit)
			return r;
		mon = top - bit_i + 1;
		if (top == 12) begin
			lm = w >> LEAP_POS;
			if (mon == lm + 1) begin
				mon = lm;
				r.leap_month = 1'b1;
			end else if (mon > lm + 1) begin
				mon--;
			end
		end
		base = (FIRST_YEAR + row - 4) % 60;
		r.date_valid   = 1'b1;
		r.lunar_year   = YEAR_W'(FIRST_YEAR + row);
		r.lunar_month  = MONTH_W'(mon);
		r.lunar_day    = DAY_W'(days);
		r.stem_index   = INDEX_W'(base % 10);
		r.branch_index = INDEX_W'(base % 12);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t ns: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic compare_field(string name, int unsigned got, int unsigned want,
		solar_entry_t e);
		if (got != want)
			report_mismatch($sformatf("%0d-%0d-%0d %s got %0d expected %0d",
				e.year, e.month, e.day, name, got, want));
	endtask

	always @(posedge clk) begin : watch
		solar_entry_t e;
		if (arst_n) begin
			if (lunar.valid && lunar.ready) begin
				results_seen <= results_seen + 1;
				if (lunar.date_valid)
					valid_seen <= valid_seen + 1;
				if (lunar.leap_month)
					leap_seen <= leap_seen + 1;
				if (pending_dates.size() == 0) begin
					report_mismatch("lunar date transfer with no solar date pending");
				end else begin
					e = pending_dates.pop_front();
					compare_field("date_valid", lunar.date_valid, e.want.date_valid, e);
					compare_field("lunar_year", lunar.lunar_year, e.want.lunar_year, e);
					compare_field("lunar_month", lunar.lunar_month, e.want.lunar_month, e);
					compare_field("leap_month", lunar.leap_month, e.want.leap_month, e);
					compare_field("lunar_day", lunar.lunar_day, e.want.lunar_day, e);
					compare_field("stem_index", lunar.stem_index, e.want.stem_index, e);
					compare_field("branch_index", lunar.branch_index,
						e.want.branch_index, e);
				end
			end
			if (solar.valid && solar.ready) begin
				e.year  = solar.solar_year;
				e.month = solar.solar_month;
				e.day   = solar.solar_day;
				e.want  = lunar_of_solar(solar.solar_year, solar.solar_month,
					solar.solar_day);
				pending_dates.push_back(e);
			end
			pending <= pending_dates.size();
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_gregorian_to_chinese_lunar_date.sv
`default_nettype none

// The top drives the solar channel and the ready of the lunar channel; the
// checker beside the converter watches both channels, predicts every result
// and counts failures.
module tb_gregorian_to_chinese_lunar_date;
	timeunit 1ns;
	timeprecision 1ps;

	import glcd_pkg::*;

	localparam int RANDOM_DATES = 400;
	// Longest walk is about 1240 months; the drain wait covers one full walk.
	localparam int DRAIN_CYCLES = 1400;
	// The receiver refuses results for this long once, so the converter fills
	// its output register and then stops taking dates.
	localparam int HOLD_CYCLES  = 3000;
	localparam int IDLE_PERCENT = 11;

	localparam int unsigned MONTH_LENGTH [12] = '{
		31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
	};

	logic clk;
	logic arst_n;

	glcd_in_if  solar_ch ();
	glcd_out_if lunar_ch ();

	int failures, pending, results_seen, valid_seen, leap_seen;
	int dates_sent;
	int directed_dates;

	// Flags shared by the two driving processes. Calm and hold_request change just
	// after a rising edge, hold_served at a falling edge; all are only read at falling edges.
	bit calm;
	bit hold_request;
	bit hold_served;

	gregorian_to_chinese_lunar_date dut (
		.clk    (clk),
		.arst_n (arst_n),
		.solar  (solar_ch),
		.lunar  (lunar_ch)
	);

	lunar_date_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.solar        (solar_ch),
		.lunar        (lunar_ch),
		.failures     (failures),
		.pending      (pending),
		.results_seen (results_seen),
		.valid_seen   (valid_seen),
		.leap_seen    (leap_seen)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Offers one date and returns at the rising edge where its transfer
	// happens. Random gaps with valid low come first unless the run is in a
	// calm stretch. Valid is never lowered here after a transfer, so a
	// back-to-back date keeps it high without a glitch.
	task automatic send_date(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
		input logic [DAY_W-1:0] d);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			solar_ch.valid <= 1'b0;
			@(negedge clk);
		end
		solar_ch.valid       <= 1'b1;
		solar_ch.solar_year  <= y;
		solar_ch.solar_month <= m;
		solar_ch.solar_day   <= d;
		do
			@(posedge clk);
		while (!solar_ch.ready);
		dates_sent++;
	endtask

	// Most random dates are real calendar dates, weighted toward the early
	// decades so that the table walks stay short. The rest are raw bit
	// patterns and dates with odd day numbers near or past the table end.
	task automatic pick_date(output logic [YEAR_W-1:0] y, output logic [MONTH_W-1:0] m,
		output logic [DAY_W-1:0] d);
		int unsigned kind, len;
		kind = $urandom_range(99);
		if (kind < 12) begin
			y = YEAR_W'($urandom);
			m = MONTH_W'($urandom);
			d = DAY_W'($urandom);
		end else if (kind < 20) begin
			y = YEAR_W'($urandom_range(2016, 2047));
			m = MONTH_W'($urandom_range(1, 12));
			len = $urandom_range(28, 31);
			d = (len == 28) ? '0 : DAY_W'(len);
		end else begin
			y = (kind < 70) ? YEAR_W'($urandom_range(1921, 1960))
			                : YEAR_W'($urandom_range(1921, 2020));
			m = MONTH_W'($urandom_range(1, 12));
			len = MONTH_LENGTH[m - 1];
			if (m == 2 && y % 4 == 0)
				len++;
			d = DAY_W'($urandom_range(1, len));
		end
	endtask

	// Receiver side: random refusals, none during the calm stretch, and one
	// long hold-off counted here while the sender keeps offering dates.
	initial begin : receiver
		int hold_cycles;
		lunar_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_served) begin
				lunar_ch.ready <= 1'b0;
				hold_cycles = 0;
				while (hold_cycles < HOLD_CYCLES) begin
					@(negedge clk);
					hold_cycles++;
				end
				hold_served = 1'b1;
			end else begin
				lunar_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	initial begin : stimulus
		logic [YEAR_W-1:0]  y;
		logic [MONTH_W-1:0] m;
		logic [DAY_W-1:0]   d;
		solar_ch.valid       = 1'b0;
		solar_ch.solar_year  = '0;
		solar_ch.solar_month = '0;
		solar_ch.solar_day   = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed dates: the epoch and the day before it, years below the
		// epoch, months out of range, intercalary months and the month after
		// one, leap days, days that spill over month ends, and the end of the
		// table including a year past 2020 that still converts.
		send_date(11'd1921, 4'd2, 5'd8);
		send_date(11'd1921, 4'd2, 5'd7);
		send_date(11'd1920, 4'd12, 5'd31);
		send_date(11'd0, 4'd0, 5'd0);
		send_date(11'd2047, 4'd15, 5'd31);
		send_date(11'd1950, 4'd0, 5'd10);
		send_date(11'd1950, 4'd13, 5'd10);
		send_date(11'd1922, 4'd6, 5'd30);
		send_date(11'd1922, 4'd8, 5'd15);
		send_date(11'd1924, 4'd2, 5'd29);
		send_date(11'd1924, 4'd3, 5'd1);
		send_date(11'd1980, 4'd2, 5'd31);
		send_date(11'd1980, 4'd3, 5'd0);
		send_date(11'd1984, 4'd2, 5'd2);
		send_date(11'd2000, 4'd1, 5'd1);
		send_date(11'd2020, 4'd6, 5'd1);
		send_date(11'd2020, 4'd12, 5'd31);
		send_date(11'd2021, 4'd1, 5'd15);
		send_date(11'd2021, 4'd2, 5'd11);
		send_date(11'd2021, 4'd2, 5'd12);
		send_date(11'd2047, 4'd12, 5'd31);
		send_date(11'd1921, 4'd12, 5'd31);
		directed_dates = dates_sent;

		for (int i = 0; i < RANDOM_DATES; i++) begin
			if (i == 0)
				hold_request = 1'b1;
			calm = (i >= 120 && i < 180);
			if (i == 300) begin
				// Let the converter drain completely before going on.
				@(negedge clk);
				solar_ch.valid <= 1'b0;
				while (pending != 0)
					@(negedge clk);
			end
			pick_date(y, m, d);
			send_date(y, m, d);
		end
		calm = 1'b0;
		@(negedge clk);
		solar_ch.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d dates (%0d directed), checked %0d results.",
			dates_sent, directed_dates, results_seen);
		$display("Results: %0d converted, %0d rejected, %0d in intercalary months.",
			valid_seen, results_seen - valid_seen, leap_seen);
		if (failures == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Safety net far above the slowest correct run: every date on a full
	// table walk, every result waiting out a receiver stall, plus the hold-off.
	initial begin : watchdog
		#40_000_000;
		$display("Timed out with %0d results pending.", pending);
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// File: sim.f
src/glcd_pkg.sv
src/glcd_if.sv
src/glcd_day_count.sv
src/glcd_month_unit.sv
src/gregorian_to_chinese_lunar_date.sv
tb/lunar_date_checker.sv
tb/tb_gregorian_to_chinese_lunar_date.sv
